[design/fos_pkg.sv]
package fos_pkg;

  // Default sizes of the two stacks.
  localparam int unsigned VALUE_DEPTH_DEF = 256;
  localparam int unsigned FRAME_DEPTH_DEF = 32;

  // Fixed field widths of the beats.
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned RET_WIDTH  = 16;
  localparam int unsigned SLOT_WIDTH = 8;

  typedef enum logic [2:0] {
    OP_PUSH       = 3'd0,
    OP_POP        = 3'd1,
    OP_LOAD       = 3'd2,
    OP_STORE      = 3'd3,
    OP_PUSH_FRAME = 3'd4,
    OP_POP_FRAME  = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_INDEX     = 3'd3,
    ST_BOTTOM    = 3'd4
  } status_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [DATA_WIDTH-1:0] data_in;
    logic [SLOT_WIDTH-1:0] slot_index;
    logic [RET_WIDTH-1:0]  return_addr_in;
    logic                  frame_kind_in;
  } in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data_out;
    logic [RET_WIDTH-1:0]  return_addr_out;
    logic [2:0]            status;
  } out_t;

endpackage

[design/fos_ram.sv]
module fos_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/fos_alu.sv]
module fos_alu import fos_pkg::*; #(
  parameter int unsigned W = 10
) (
  input  alu_op_e      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] limit_i,
  output logic [W-1:0] res_o,
  output logic         lt_o
);

  // Shared adder and bound compare used for value stack addresses, pop counts and bound checks.
  always_comb begin
    if (op_i == ALU_SUB) begin
      res_o = a_i - b_i;
    end else begin
      res_o = a_i + b_i;
    end
    lt_o = (res_o < limit_i);
  end

endmodule

[design/framed_operand_stack_core.sv]
// Operand stack with frames for a virtual machine. Each input beat carries one
// opcode (push, pop, load slot, store slot, push frame, pop frame) and gives
// exactly one result beat with the popped or loaded value, the return address
// of a popped frame and a status code; a fault changes no state. Items are
// handled one at a time: in_ready_o is high only while the block is idle. A
// result beat is offered after the execute state, or, for a pop, load or pop
// frame that succeeds, after a further read state that waits for the registered
// read of a stack memory; ready returns in the cycle after the result beat is
// taken. Load and store address the base of the nearest function frame, which
// is held in a register for the top frame and saved with each outer frame, so
// no frame walk is needed.
module framed_operand_stack_core import fos_pkg::*; #(
  parameter int unsigned VALUE_DEPTH = VALUE_DEPTH_DEF,
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int unsigned VCW = $clog2(VALUE_DEPTH + 1);
  localparam int unsigned VAW = $clog2(VALUE_DEPTH);
  localparam int unsigned FCW = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned FAW = $clog2(FRAME_DEPTH);
  localparam int unsigned AW  = ((VCW > SLOT_WIDTH) ? VCW : SLOT_WIDTH) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DONE
  } state_e;

  // Record of a frame that lies below the top frame.
  typedef struct packed {
    logic [VCW-1:0]       len;
    logic [RET_WIDTH-1:0] ret;
    logic [VCW-1:0]       fbase;
  } frame_rec_t;

  state_e               state_q, state_d;
  in_t                  item_q, item_d;
  out_t                 out_q, out_d;
  logic [VCW-1:0]       vc_q, vc_d;
  logic [FCW-1:0]       fc_q, fc_d;
  logic [VCW-1:0]       top_len_q, top_len_d;
  logic [RET_WIDTH-1:0] top_ret_q, top_ret_d;
  logic [VCW-1:0]       top_fbase_q, top_fbase_d;

  opcode_e              op;
  alu_op_e              alu_op;
  logic [AW-1:0]        alu_a, alu_b, alu_limit, alu_res;
  logic                 alu_lt;

  logic                 val_we, val_re;
  logic [VAW-1:0]       val_waddr, val_raddr;
  logic [DATA_WIDTH-1:0] val_rdata;

  logic                 frm_we, frm_re;
  logic [FAW-1:0]       frm_waddr, frm_raddr;
  frame_rec_t           frm_wdata;
  logic [$bits(frame_rec_t)-1:0] frm_rdata;
  frame_rec_t           frm_rec;

  assign op      = opcode_e'(item_q.opcode);
  assign frm_rec = frame_rec_t'(frm_rdata);

  // Value stack memory.
  fos_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(VALUE_DEPTH)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(item_q.data_in),
    .re_i   (val_re),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  // Saved records of the frames below the top frame.
  fos_ram #(
    .WIDTH($bits(frame_rec_t)),
    .DEPTH(FRAME_DEPTH)
  ) u_frm_ram (
    .clk_i  (clk_i),
    .we_i   (frm_we),
    .waddr_i(frm_waddr),
    .wdata_i(frm_wdata),
    .re_i   (frm_re),
    .raddr_i(frm_raddr),
    .rdata_o(frm_rdata)
  );

  fos_alu #(
    .W(AW)
  ) u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .limit_i(alu_limit),
    .res_o  (alu_res),
    .lt_o   (alu_lt)
  );

  // Operands of the shared unit for the held opcode.
  always_comb begin
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    alu_limit = '0;
    case (op)
      OP_PUSH: begin
        alu_a     = AW'(vc_q);
        alu_limit = AW'(VALUE_DEPTH);
      end
      OP_POP: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(vc_q);
        alu_b  = AW'(1);
      end
      OP_LOAD, OP_STORE: begin
        alu_a     = AW'(top_fbase_q);
        alu_b     = AW'(item_q.slot_index);
        alu_limit = AW'(vc_q);
      end
      OP_POP_FRAME: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(vc_q);
        alu_b  = AW'(top_len_q);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // Sequencer: take a beat, execute, wait for a memory read if one is needed, offer the result.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    out_d       = out_q;
    vc_d        = vc_q;
    fc_d        = fc_q;
    top_len_d   = top_len_q;
    top_ret_d   = top_ret_q;
    top_fbase_d = top_fbase_q;
    val_we      = 1'b0;
    val_re      = 1'b0;
    val_waddr   = vc_q[VAW-1:0];
    val_raddr   = alu_res[VAW-1:0];
    frm_we      = 1'b0;
    frm_re      = 1'b0;
    frm_waddr   = FAW'(fc_q - FCW'(1));
    frm_raddr   = FAW'(fc_q - FCW'(2));
    frm_wdata   = '{len: top_len_q, ret: top_ret_q, fbase: top_fbase_q};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        out_d   = '0;
        out_d.status = ST_OK;
        state_d = S_DONE;
        case (op)
          OP_PUSH: begin
            if (!alu_lt) begin
              out_d.status = ST_OVERFLOW;
            end else begin
              val_we    = 1'b1;
              vc_d      = vc_q + VCW'(1);
              top_len_d = top_len_q + VCW'(1);
            end
          end
          OP_POP: begin
            if (top_len_q == '0 || vc_q == '0) begin
              out_d.status = ST_UNDERFLOW;
            end else begin
              val_re    = 1'b1;
              vc_d      = alu_res[VCW-1:0];
              top_len_d = top_len_q - VCW'(1);
              state_d   = S_READ;
            end
          end
          OP_LOAD: begin
            if (!alu_lt) begin
              out_d.status = ST_INDEX;
            end else begin
              val_re  = 1'b1;
              state_d = S_READ;
            end
          end
          OP_STORE: begin
            if (!alu_lt) begin
              out_d.status = ST_INDEX;
            end else begin
              val_we    = 1'b1;
              val_waddr = alu_res[VAW-1:0];
            end
          end
          OP_PUSH_FRAME: begin
            if (fc_q >= FCW'(FRAME_DEPTH)) begin
              out_d.status = ST_OVERFLOW;
            end else begin
              frm_we      = 1'b1;
              fc_d        = fc_q + FCW'(1);
              top_len_d   = '0;
              top_ret_d   = item_q.return_addr_in;
              top_fbase_d = item_q.frame_kind_in ? top_fbase_q : vc_q;
            end
          end
          OP_POP_FRAME: begin
            if (fc_q <= FCW'(1)) begin
              out_d.status = ST_BOTTOM;
            end else begin
              out_d.return_addr_out = top_ret_q;
              vc_d    = alu_res[VCW-1:0];
              fc_d    = fc_q - FCW'(1);
              frm_re  = 1'b1;
              state_d = S_READ;
            end
          end
          default: begin
            out_d.status = ST_OK;
          end
        endcase
      end
      S_READ: begin
        if (op == OP_POP_FRAME) begin
          top_len_d   = frm_rec.len;
          top_ret_d   = frm_rec.ret;
          top_fbase_d = frm_rec.fbase;
        end else begin
          out_d.data_out = val_rdata;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vc_q        <= '0;
      fc_q        <= FCW'(1);
      top_len_q   <= '0;
      top_ret_q   <= '0;
      top_fbase_q <= '0;
    end else begin
      state_q     <= state_d;
      vc_q        <= vc_d;
      fc_q        <= fc_d;
      top_len_q   <= top_len_d;
      top_ret_q   <= top_ret_d;
      top_fbase_q <= top_fbase_d;
    end
  end

  // Beat payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign out_o       = out_q;

`ifndef SYNTHESIS
  // The top frame never holds more values than the whole stack. While a frame
  // record is being restored the old length is still held, so that cycle is
  // left out.
  a_len_in_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_READ) |-> (top_len_q <= vc_q))
    else $error("top frame length exceeds value count");

  // The addressed base never lies above the stack top.
  a_base_in_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_fbase_q <= vc_q) else $error("function frame base above value count");

  // The frame count stays between the bottom frame and the frame depth.
  a_fc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q >= FCW'(1) && fc_q <= FCW'(FRAME_DEPTH)) else $error("frame count out of range");

  // The value count never exceeds the value depth.
  a_vc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q <= VCW'(VALUE_DEPTH)) else $error("value count out of range");

  // A successful push frame leaves an empty top frame.
  a_push_frame_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_we |=> top_len_q == '0) else $error("new frame not empty");
`endif

endmodule
